// ===== rtl/drq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drq_pkg: shared types and codes for the deadline run queue scheduler
// Probe and command records that travel along and into the rows of queue cells.
// ----------------------------------------------------------------------------
package drq_pkg;

   // Slot index width covers the largest supported queue depth of 256 entries.
   localparam int SLOT_W = 8;

   typedef logic [SLOT_W-1:0] slot_type;

   localparam logic [63:0] ALL_ONES = '1;

   localparam logic [1:0] REG_SLICE    = 2'd0;
   localparam logic [1:0] REG_PRIO_MAX = 2'd1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // A probe walks one cell per cycle. For an insert, flag marks a key match
   // and idx the first free slot; for an acquire, flag marks a found entry and
   // idx, key and thread describe the smallest key seen so far.
   typedef struct packed {
      logic        active;
      logic        acq;
      logic [63:0] key;
      logic        flag;
      logic [15:0] thread;
      slot_type    idx;
      logic        free;
   } probe_type;

   typedef struct packed {
      logic        wr;
      logic        clr;
      slot_type    idx;
      logic [63:0] key;
      logic [15:0] thread;
   } cmd_type;

   function automatic logic [63:0] next_key(input logic [63:0] k);
      logic [63:0] n;
      n = k + 64'd1;
      return (n == ALL_ONES) ? 64'd0 : n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/drq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drq_cell: one run queue slot
// Holds one entry and updates the passing probe before handing it onward.
// ----------------------------------------------------------------------------
module drq_cell #(
   parameter int IDX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  var  drq_pkg::probe_type probe_in,
   output var  drq_pkg::probe_type probe_out,
   input  var  drq_pkg::cmd_type   cmd
);
   import drq_pkg::*;

   localparam slot_type MY_SLOT = slot_type'(IDX);

   logic        valid_ff, valid_in;
   logic [63:0] dl_ff, dl_in;
   logic [15:0] th_ff, th_in;
   probe_type   probe_ff, probe_next_in;

   always_comb begin
      probe_type p;
      p        = probe_in;
      valid_in = valid_ff;
      dl_in    = dl_ff;
      th_in    = th_ff;
      if (p.active && valid_ff) begin
         if (p.acq) begin
            if (!p.flag || dl_ff < p.key) begin
               p.flag   = 1'b1;
               p.key    = dl_ff;
               p.thread = th_ff;
               p.idx    = MY_SLOT;
            end
         end else if (dl_ff == p.key) begin
            p.key  = next_key(p.key);
            p.flag = 1'b1;
         end
      end else if (p.active && !p.acq && !p.free) begin
         p.free = 1'b1;
         p.idx  = MY_SLOT;
      end
      probe_next_in = p;
      if (cmd.idx == MY_SLOT) begin
         if (cmd.wr) begin
            valid_in = 1'b1;
            dl_in    = cmd.key;
            th_in    = cmd.thread;
         end else if (cmd.clr) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_next_in;
      end
      dl_ff <= dl_in;
      th_ff <= th_in;
   end

   assign probe_out = probe_ff;

endmodule
`default_nettype wire

// ===== rtl/drq_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drq_queue: one per-CPU run queue
// A row of slot cells through which a probe travels one cell per cycle.
// ----------------------------------------------------------------------------
module drq_queue #(
   parameter int QUEUE_ENTRIES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  var  drq_pkg::probe_type probe_in,
   output var  drq_pkg::probe_type probe_out,
   input  var  drq_pkg::cmd_type   cmd
);
   import drq_pkg::*;

   probe_type chain [QUEUE_ENTRIES+1];

   assign chain[0] = probe_in;

   for (genvar i = 0; i < QUEUE_ENTRIES; i++) begin : g_cell
      drq_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[i]),
         .probe_out (chain[i+1]),
         .cmd       (cmd)
      );
   end

   assign probe_out = chain[QUEUE_ENTRIES];

endmodule
`default_nettype wire

// ===== rtl/deadline_run_queue_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_run_queue_scheduler: per-CPU run queues keyed by virtual deadline
// Inserts waiting threads with a unique deadline and hands out the earliest.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Contents
// req_      in         req_valid/req_stall   insert or acquire transaction
// rsp_      out        rsp_valid/rsp_stall   one result per transaction
// csr_      in         csr_write_enable      time slice and priority ceiling writes
//
// An insert passes through S_MUL and S_ADD, then makes P probe passes through
// the target row of cells (one, plus one per bump round) before S_OUT.
// An acquire probes all rows in parallel in S_ACQ_SCAN, then S_ACQ_PICK
// compares the row results in rotation order.
// A dropped insert goes straight to S_OUT. Reset empties all queues at once.
// A new transaction is taken while an earlier result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module deadline_run_queue_scheduler #(
   parameter int NUM_QUEUES    = 4,
   parameter int QUEUE_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output var  logic        req_stall,
   input  wire logic        req_mode,
   input  wire logic [1:0]  req_cpu,
   input  wire logic [15:0] req_thread_handle,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [63:0] req_now,
   input  wire logic        req_is_waiting,
   output var  logic        rsp_valid,
   input  wire logic        rsp_stall,
   output var  logic        rsp_granted,
   output var  logic [15:0] rsp_out_thread,
   output var  logic [63:0] rsp_out_deadline,
   output var  logic [1:0]  rsp_out_queue,
   output var  logic [1:0]  rsp_status,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import drq_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CW = $clog2(NUM_QUEUES + 1);
   localparam logic [QW-1:0] LAST_Q = QW'(NUM_QUEUES - 1);
   localparam logic [CW-1:0] LAST_C = CW'(NUM_QUEUES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_ADD, S_INS_SCAN, S_ACQ_SCAN, S_ACQ_PICK, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] rr_ff, rr_in;
   logic [7:0]  pmax_ff, pmax_in;
   logic [QW-1:0] q_ff, q_in;
   logic [15:0] handle_ff, handle_in;
   logic [7:0]  prio_ff, prio_in;
   logic [63:0] now_ff, now_in;
   logic [23:0] prod_ff, prod_in;
   logic [63:0] key_ff, key_in;
   logic        inj_ins_ff, inj_ins_in;
   logic        inj_acq_ff, inj_acq_in;
   probe_type   cap_ff [NUM_QUEUES];
   probe_type   cap_in [NUM_QUEUES];
   logic [QW-1:0] qq_ff, qq_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        found_ff, found_in;
   logic [63:0] bkey_ff, bkey_in;
   logic [15:0] bthread_ff, bthread_in;
   logic [QW-1:0] bq_ff, bq_in;
   slot_type    bidx_ff, bidx_in;
   logic        wr_ff, wr_in;
   logic        clr_ff, clr_in;
   logic [QW-1:0] cmd_q_ff, cmd_q_in;
   slot_type    cmd_idx_ff, cmd_idx_in;
   logic        res_granted_ff, res_granted_in;
   logic [15:0] res_thread_ff, res_thread_in;
   logic [63:0] res_dl_ff, res_dl_in;
   logic [1:0]  res_queue_ff, res_queue_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_granted_ff, rsp_granted_in;
   logic [15:0] rsp_thread_ff, rsp_thread_in;
   logic [63:0] rsp_dl_ff, rsp_dl_in;
   logic [1:0]  rsp_queue_ff, rsp_queue_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   probe_type   probe_to [NUM_QUEUES];
   probe_type   probe_from [NUM_QUEUES];
   cmd_type     cmds [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] emerge;

   function automatic logic [QW-1:0] cpu_to_queue(input logic [1:0] cpu);
      logic [4:0] r;
      r = {3'b000, cpu};
      for (int i = 0; i < 3; i++) begin
         if (r >= 5'(NUM_QUEUES)) begin
            r = r - 5'(NUM_QUEUES);
         end
      end
      return QW'(r);
   endfunction

   for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
      always_comb begin
         probe_to[g]        = '0;
         probe_to[g].active = inj_acq_ff || (inj_ins_ff && q_ff == QW'(g));
         probe_to[g].acq    = inj_acq_ff;
         probe_to[g].key    = key_ff;
         cmds[g].wr         = wr_ff && cmd_q_ff == QW'(g);
         cmds[g].clr        = clr_ff && cmd_q_ff == QW'(g);
         cmds[g].idx        = cmd_idx_ff;
         cmds[g].key        = key_ff;
         cmds[g].thread     = handle_ff;
      end
      assign emerge[g] = probe_from[g].active;

      drq_queue #(.QUEUE_ENTRIES(QUEUE_ENTRIES)) u_queue (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (probe_to[g]),
         .probe_out (probe_from[g]),
         .cmd       (cmds[g])
      );
   end

   always_comb begin
      probe_type   po;
      logic [7:0]  ratio;
      logic [63:0] sum;
      logic        f;
      logic [63:0] bk;
      logic [15:0] bt;
      logic [QW-1:0] bq;
      slot_type    bi;

      state_in       = state_ff;
      rr_in          = rr_ff;
      pmax_in        = pmax_ff;
      q_in           = q_ff;
      handle_in      = handle_ff;
      prio_in        = prio_ff;
      now_in         = now_ff;
      prod_in        = prod_ff;
      key_in         = key_ff;
      inj_ins_in     = 1'b0;
      inj_acq_in     = 1'b0;
      cap_in         = cap_ff;
      qq_in          = qq_ff;
      cnt_in         = cnt_ff;
      found_in       = found_ff;
      bkey_in        = bkey_ff;
      bthread_in     = bthread_ff;
      bq_in          = bq_ff;
      bidx_in        = bidx_ff;
      wr_in          = 1'b0;
      clr_in         = 1'b0;
      cmd_q_in       = cmd_q_ff;
      cmd_idx_in     = cmd_idx_ff;
      res_granted_in = res_granted_ff;
      res_thread_in  = res_thread_ff;
      res_dl_in      = res_dl_ff;
      res_queue_in   = res_queue_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_thread_in  = rsp_thread_ff;
      rsp_dl_in      = rsp_dl_ff;
      rsp_queue_in   = rsp_queue_ff;
      rsp_status_in  = rsp_status_ff;
      po             = probe_from[q_ff];
      ratio          = (prio_ff > pmax_ff) ? 8'd0 : pmax_ff - prio_ff;
      sum            = now_ff + 64'(prod_ff);
      f              = found_ff;
      bk             = bkey_ff;
      bt             = bthread_ff;
      bq             = bq_ff;
      bi             = bidx_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            REG_SLICE:    rr_in   = csr_write_data;
            REG_PRIO_MAX: pmax_in = csr_write_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_in      = cpu_to_queue(req_cpu);
               handle_in = req_thread_handle;
               prio_in   = req_priority_req;
               now_in    = req_now;
               if (req_mode) begin
                  inj_acq_in = 1'b1;
                  state_in   = S_ACQ_SCAN;
               end else if (!req_is_waiting) begin
                  res_granted_in = 1'b0;
                  res_thread_in  = req_thread_handle;
                  res_dl_in      = 64'd0;
                  res_queue_in   = 2'(cpu_to_queue(req_cpu));
                  res_status_in  = ST_IGNORED;
                  state_in       = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in  = ratio * rr_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            key_in     = (sum == ALL_ONES) ? 64'd0 : sum;
            inj_ins_in = 1'b1;
            state_in   = S_INS_SCAN;
         end
         S_INS_SCAN: begin
            if (po.active) begin
               res_granted_in = 1'b0;
               res_thread_in  = handle_ff;
               res_queue_in   = 2'(q_ff);
               if (!po.free) begin
                  res_dl_in     = 64'd0;
                  res_status_in = ST_FULL;
                  state_in      = S_OUT;
               end else if (po.flag) begin
                  key_in     = po.key;
                  inj_ins_in = 1'b1;
               end else begin
                  key_in        = po.key;
                  wr_in         = 1'b1;
                  cmd_q_in      = q_ff;
                  cmd_idx_in    = po.idx;
                  res_dl_in     = po.key;
                  res_status_in = ST_OK;
                  state_in      = S_OUT;
               end
            end
         end
         S_ACQ_SCAN: begin
            if (emerge[0]) begin
               cap_in   = probe_from;
               qq_in    = q_ff;
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_ACQ_PICK;
            end
         end
         S_ACQ_PICK: begin
            if (cap_ff[qq_ff].flag && (!found_ff || cap_ff[qq_ff].key < bkey_ff)) begin
               f  = 1'b1;
               bk = cap_ff[qq_ff].key;
               bt = cap_ff[qq_ff].thread;
               bq = qq_ff;
               bi = cap_ff[qq_ff].idx;
            end
            found_in   = f;
            bkey_in    = bk;
            bthread_in = bt;
            bq_in      = bq;
            bidx_in    = bi;
            qq_in      = (qq_ff == LAST_Q) ? '0 : qq_ff + QW'(1);
            cnt_in     = cnt_ff + CW'(1);
            if (cnt_ff == LAST_C) begin
               if (f) begin
                  clr_in         = 1'b1;
                  cmd_q_in       = bq;
                  cmd_idx_in     = bi;
                  res_granted_in = 1'b1;
                  res_thread_in  = bt;
                  res_dl_in      = bk;
                  res_queue_in   = 2'(bq);
                  res_status_in  = ST_OK;
               end else begin
                  res_granted_in = 1'b0;
                  res_thread_in  = 16'd0;
                  res_dl_in      = 64'd0;
                  res_queue_in   = 2'(q_ff);
                  res_status_in  = ST_EMPTY;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_thread_in  = res_thread_ff;
               rsp_dl_in      = res_dl_ff;
               rsp_queue_in   = res_queue_ff;
               rsp_status_in  = res_status_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rr_ff        <= 16'd6;
         pmax_ff      <= 8'd7;
         inj_ins_ff   <= 1'b0;
         inj_acq_ff   <= 1'b0;
         wr_ff        <= 1'b0;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rr_ff        <= rr_in;
         pmax_ff      <= pmax_in;
         inj_ins_ff   <= inj_ins_in;
         inj_acq_ff   <= inj_acq_in;
         wr_ff        <= wr_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff           <= q_in;
      handle_ff      <= handle_in;
      prio_ff        <= prio_in;
      now_ff         <= now_in;
      prod_ff        <= prod_in;
      key_ff         <= key_in;
      cap_ff         <= cap_in;
      qq_ff          <= qq_in;
      cnt_ff         <= cnt_in;
      found_ff       <= found_in;
      bkey_ff        <= bkey_in;
      bthread_ff     <= bthread_in;
      bq_ff          <= bq_in;
      bidx_ff        <= bidx_in;
      cmd_q_ff       <= cmd_q_in;
      cmd_idx_ff     <= cmd_idx_in;
      res_granted_ff <= res_granted_in;
      res_thread_ff  <= res_thread_in;
      res_dl_ff      <= res_dl_in;
      res_queue_ff   <= res_queue_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_thread_ff  <= rsp_thread_in;
      rsp_dl_ff      <= rsp_dl_in;
      rsp_queue_ff   <= rsp_queue_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_out_thread   = rsp_thread_ff;
   assign rsp_out_deadline = rsp_dl_ff;
   assign rsp_out_queue    = rsp_queue_ff;
   assign rsp_status       = rsp_status_ff;

   // An accepted transaction always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted transaction did not start");

   // Acquire probes are launched together, so they leave all rows together.
   a_acq_lockstep: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACQ_SCAN |-> (emerge == '0) || (&emerge))
      else $error("acquire probes out of step");

   // An insert probes only its own row.
   a_ins_single: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_SCAN |-> $countones(emerge) <= 1)
      else $error("more than one insert probe active");

   // A granted thread is always reported with a good status.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_granted_ff |-> rsp_status_ff == ST_OK)
      else $error("grant with bad status");

   // Storage is never written and cleared in the same cycle.
   a_wr_clr: assert property (@(posedge clock) disable iff (reset)
      !(wr_ff && clr_ff))
      else $error("write and clear collide");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the deadline run queue scheduler
// Sends insert and acquire transactions in random bursts against a stalling
// receiver. It predicts each result from a model of the per-CPU queues and
// compares every field. Several register settings are used, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb;
   import drq_pkg::*;

   localparam int NQ = 4;
   localparam int NE = 16;
   localparam logic [1:0] REG_UNUSED      = 2'd3;
   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_ACQUIRE = 1'b1;

   typedef struct packed {
      logic        granted;
      logic [15:0] thread;
      logic [63:0] deadline;
      logic [1:0]  queue;
      logic [1:0]  status;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic [1:0] req_cpu = '0;
   logic [15:0] req_thread_handle = '0;
   logic [7:0] req_priority_req = '0;
   logic [63:0] req_now = '0;
   logic req_is_waiting = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_granted;
   logic [15:0] rsp_out_thread;
   logic [63:0] rsp_out_deadline;
   logic [1:0] rsp_out_queue;
   logic [1:0] rsp_status;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;

   logic [15:0] slice_len;
   logic [7:0] prio_max;
   logic slot_used [NQ*NE];
   logic [63:0] slot_key [NQ*NE];
   logic [15:0] slot_thread [NQ*NE];

   sched_result_type pending_results [$];
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_granted = 0;
   int n_full = 0;
   int n_bumped = 0;
   int burst_left = 0;
   int stall_style = 0;
   int stall_count = 0;

   deadline_run_queue_scheduler #(.NUM_QUEUES(NQ), .QUEUE_ENTRIES(NE)) u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic key_in_queue(input int q, input logic [63:0] key);
      for (int i = 0; i < NE; i++)
         if (slot_used[q*NE+i] && slot_key[q*NE+i] == key) return 1'b1;
      return 1'b0;
   endfunction

   function automatic sched_result_type schedule(input logic mode, input logic [1:0] cpu,
         input logic [15:0] handle, input logic [7:0] prio, input logic [63:0] tick,
         input logic waiting);
      sched_result_type r;
      int q, free_slot, best_slot;
      logic [63:0] ratio, key;
      logic found;
      q = cpu % NQ;
      r = '{1'b0, handle, 64'd0, 2'(q), ST_OK};
      if (mode == MODE_INSERT) begin
         if (!waiting) begin
            r.status = ST_IGNORED;
            return r;
         end
         free_slot = -1;
         for (int i = NE - 1; i >= 0; i--)
            if (!slot_used[q*NE+i]) free_slot = q*NE + i;
         if (free_slot < 0) begin
            r.status = ST_FULL;
            n_full++;
            return r;
         end
         ratio = (prio > prio_max) ? 64'd0 : 64'(prio_max - prio);
         key = tick + ratio * 64'(slice_len);
         if (key == ALL_ONES) key = '0;
         if (key_in_queue(q, key)) n_bumped++;
         while (key_in_queue(q, key)) begin
            key = key + 64'd1;
            if (key == ALL_ONES) key = '0;
         end
         slot_used[free_slot] = 1'b1;
         slot_key[free_slot] = key;
         slot_thread[free_slot] = handle;
         r.deadline = key;
         return r;
      end
      found = 1'b0;
      best_slot = 0;
      for (int k = 0; k < NQ; k++)
         for (int i = 0; i < NE; i++) begin
            int s;
            s = ((q + k) % NQ) * NE + i;
            if (slot_used[s] && (!found || slot_key[s] < slot_key[best_slot])) begin
               found = 1'b1;
               best_slot = s;
            end
         end
      if (!found) begin
         r.thread = '0;
         r.status = ST_EMPTY;
         return r;
      end
      slot_used[best_slot] = 1'b0;
      n_granted++;
      return '{1'b1, slot_thread[best_slot], slot_key[best_slot], 2'(best_slot / NE), ST_OK};
   endfunction

   // Starts and ends at a falling edge; valid stays high within a burst.
   task automatic send_txn(input logic mode, input logic [1:0] cpu,
         input logic [15:0] handle, input logic [7:0] prio, input logic [63:0] tick,
         input logic waiting);
      req_mode = mode;
      req_cpu = cpu;
      req_thread_handle = handle;
      req_priority_req = prio;
      req_now = tick;
      req_is_waiting = waiting;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(schedule(mode, cpu, handle, prio, tick, waiting));
      n_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 25) : 0) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic insert(input logic [1:0] cpu, input logic [15:0] handle,
         input logic [7:0] prio, input logic [63:0] tick);
      send_txn(MODE_INSERT, cpu, handle, prio, tick, 1'b1);
   endtask

   task automatic acquire(input logic [1:0] cpu);
      send_txn(MODE_ACQUIRE, cpu, 16'($urandom), 8'($urandom), {$urandom, $urandom},
               1'($urandom));
   endtask

   task automatic drain;
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      drain();
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == REG_SLICE) slice_len = value;
      else if (idx == REG_PRIO_MAX) prio_max = value[7:0];
   endtask

   task automatic empty_all;
      for (int i = 0; i < NQ * NE + 1; i++) acquire(2'($urandom));
   endtask

   task automatic test_edge_cases;
      acquire(2'd2);
      send_txn(MODE_INSERT, 2'd1, 16'hFFFF, 8'd0, ALL_ONES, 1'b0);
      insert(2'd0, 16'hFFFF, 8'd7, ALL_ONES);
      insert(2'd0, 16'h0001, 8'd7, ALL_ONES - 64'd1);
      insert(2'd0, 16'h0002, 8'd7, ALL_ONES - 64'd1);
      insert(2'd0, 16'h0003, 8'd255, ALL_ONES - 64'd1);
      insert(2'd3, 16'h0000, 8'd0, 64'd0);
      insert(2'd2, 16'h1234, 8'd200, 64'd42);
      insert(2'd1, 16'h4321, 8'd7, 64'd42);
      insert(2'd2, 16'h5555, 8'd3, 64'd30);
      for (int i = 0; i < 9; i++) acquire(2'(i));
   endtask

   task automatic test_queue_full;
      for (int i = 0; i < NE + 2; i++) insert(2'd3, 16'(i), 8'd1, 64'd100);
      insert(2'd0, 16'hAAAA, 8'd1, 64'd100);
      acquire(2'd0);
      acquire(2'd3);
      empty_all();
   endtask

   task automatic test_random(input int n);
      logic [63:0] tick;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: tick = {$urandom, $urandom};
            1: tick = ALL_ONES - 64'($urandom_range(0, 40));
            default: tick = 64'($urandom_range(0, 60));
         endcase
         if (pick < 55) insert(2'($urandom), 16'($urandom), 8'($urandom_range(0, 255)), tick);
         else if (pick < 90) acquire(2'($urandom));
         else send_txn(MODE_INSERT, 2'($urandom), 16'($urandom), 8'($urandom), tick, 1'b0);
      end
   endtask

   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_count = $urandom_range(20, 120);
      end
      stall_count--;
      case (stall_style)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         default: rsp_stall = ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      sched_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction on rsp_ channel");
            errors++;
         end else begin
            exp = pending_results.pop_front();
            n_checked++;
            if (rsp_granted !== exp.granted) begin
               $error("granted: expected %0d, got %0d", exp.granted, rsp_granted);
               errors++;
            end
            if (rsp_out_thread !== exp.thread) begin
               $error("out_thread: expected %0h, got %0h", exp.thread, rsp_out_thread);
               errors++;
            end
            if (rsp_out_deadline !== exp.deadline) begin
               $error("out_deadline: expected %0h, got %0h", exp.deadline, rsp_out_deadline);
               errors++;
            end
            if (rsp_out_queue !== exp.queue) begin
               $error("out_queue: expected %0d, got %0d", exp.queue, rsp_out_queue);
               errors++;
            end
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      slice_len = 16'd6;
      prio_max = 8'd7;
      for (int i = 0; i < NQ * NE; i++) slot_used[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_edge_cases();
      test_queue_full();
      write_reg(REG_SLICE, 16'd1);
      write_reg(REG_PRIO_MAX, 16'd0);
      test_random(200);
      write_reg(REG_SLICE, 16'hFFFF);
      write_reg(REG_PRIO_MAX, 16'd255);
      insert(2'd1, 16'hBEEF, 8'd0, ALL_ONES - 64'd1);
      test_random(300);
      write_reg(REG_UNUSED, 16'h0000);
      write_reg(REG_SLICE, 16'($urandom_range(1, 65535)));
      write_reg(REG_PRIO_MAX, 16'($urandom_range(0, 255)));
      test_random(300);
      write_reg(REG_SLICE, 16'd3);
      write_reg(REG_PRIO_MAX, 16'd20);
      test_random(280);
      drain();
      $display("%0d transactions sent, %0d results checked: %0d grants, %0d full queues,",
               n_sent, n_checked, n_granted, n_full);
      $display("%0d deadline bumps over five register settings", n_bumped);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== deadline_run_queue_scheduler.f =====
rtl/drq_pkg.sv
rtl/drq_cell.sv
rtl/drq_queue.sv
rtl/deadline_run_queue_scheduler.sv
verif/tb.sv
